/* sv/assert_macros.svh */
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* sv/hpdc_pkg.sv */
package hpdc_pkg;

  localparam int WORD_BITS   = 64;
  localparam int ALLELE_BITS = 8;

  // fixed field widths on the stream
  localparam int DATA_W   = 64;
  localparam int ALLELE_W = 8;
  localparam int CNT_W    = 32;
  localparam int TDATA_W  = 2 * DATA_W + 2 * ALLELE_W;
  localparam int OUT_W    = 3 * CNT_W;

  localparam int INC_W      = $clog2(WORD_BITS + 1);
  localparam int ALLELE_USE = (ALLELE_BITS < ALLELE_W) ? ALLELE_BITS : ALLELE_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_BIALLELIC = 1'b0,
    OP_MULTI     = 1'b1
  } hpdc_op_e;

  // per-item increments handed from front to back
  typedef struct packed {
    logic [INC_W-1:0] same;
    logic [INC_W-1:0] either;
    logic [INC_W-1:0] diff;
    logic             last;
  } hpdc_incr_t;

  // adder tree popcount over the low WORD_BITS bits
  function automatic logic [INC_W-1:0] ones_in(logic [WORD_BITS-1:0] w);
    logic [INC_W-1:0] v [WORD_BITS];
    for (int i = 0; i < WORD_BITS; i++) begin
      v[i] = INC_W'(w[i]);
    end
    for (int s = 1; s < WORD_BITS; s = s * 2) begin
      for (int i = 0; i + s < WORD_BITS; i = i + 2 * s) begin
        v[i] = v[i] + v[i+s];
      end
    end
    return v[0];
  endfunction

endpackage

/* sv/haplotype_pair_distance_counts.sv */
// a last item passes through the queue and the output register before its result shows on m_axis
// one item per cycle unless the queue is full; front popcounts on accept, back adds per pop
// a result waiting on m_axis_tready stalls only a later last item, others keep accumulating
// reset (rst_ni low, async): counts cleared to zero, queue emptied, no result pending
module haplotype_pair_distance_counts (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // word_a [63:0], word_b [127:64], allele_a [135:128], allele_b [143:136]
  input  logic [hpdc_pkg::TDATA_W-1:0]  s_axis_tdata,
  // op (0 biallelic word pair, 1 multi-allelic allele pair)
  input  logic                          s_axis_tuser,
  // last item of the haplotype pair
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // same_in_both [31:0], present_in_either [63:32], differing [95:64]
  output logic [hpdc_pkg::OUT_W-1:0]    m_axis_tdata
);
  import hpdc_pkg::*;

  `include "assert_macros.svh"

  // front to queue
  hpdc_incr_t f_item;
  logic       f_push;
  logic       q_full;

  // queue to back
  hpdc_incr_t q_item;
  logic       q_valid;
  logic       q_pop;

  // front: accept and turn each item into three increments
  hpdc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .push_o        (f_push),
    .item_o        (f_item)
  );

  // short queue so a stalled result does not block accepts at once
  hpdc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  // back: saturating accumulate, emit and clear on last
  hpdc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // the front never writes into a full queue
  `ASSERT_NEVER(a_no_overflow, f_push && q_full)
  // and-count never exceeds or-count
  `ASSERT_NEVER(a_incr_order, f_push && (f_item.same > f_item.either))
  // a new result only follows a popped last item
  `ASSERT_IMPLIES(a_result_src, $rose(m_axis_tvalid), $past(q_pop && q_item.last))
  // a pop needs a valid queue head
  `ASSERT_IMPLIES(a_pop_valid, q_pop, q_valid)

endmodule

/* sv/hpdc_front.sv */
module hpdc_front (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hpdc_pkg::TDATA_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  input  logic                          q_full_i,
  output logic                          push_o,
  output hpdc_pkg::hpdc_incr_t          item_o
);
  import hpdc_pkg::*;

  logic [DATA_W-1:0]   word_a, word_b;
  logic [ALLELE_W-1:0] allele_a, allele_b;
  logic [ALLELE_USE-1:0] al_a, al_b;
  logic both_nz, al_eq;

  assign word_a   = s_axis_tdata[DATA_W-1:0];
  assign word_b   = s_axis_tdata[2*DATA_W-1:DATA_W];
  assign allele_a = s_axis_tdata[2*DATA_W +: ALLELE_W];
  assign allele_b = s_axis_tdata[2*DATA_W+ALLELE_W +: ALLELE_W];

  assign al_a    = allele_a[ALLELE_USE-1:0];
  assign al_b    = allele_b[ALLELE_USE-1:0];
  assign both_nz = (|al_a) && (|al_b);
  assign al_eq   = (al_a == al_b);

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  always_comb begin
    item_o.last = s_axis_tlast;
    case (hpdc_op_e'(s_axis_tuser))
      OP_BIALLELIC: begin
        item_o.same   = ones_in(word_a[WORD_BITS-1:0] & word_b[WORD_BITS-1:0]);
        item_o.either = ones_in(word_a[WORD_BITS-1:0] | word_b[WORD_BITS-1:0]);
        item_o.diff   = ones_in(word_a[WORD_BITS-1:0] ^ word_b[WORD_BITS-1:0]);
      end
      OP_MULTI: begin
        item_o.same   = INC_W'(both_nz && al_eq);
        item_o.either = INC_W'(both_nz);
        item_o.diff   = INC_W'(!al_eq);
      end
      default: begin
        item_o.same   = '0;
        item_o.either = '0;
        item_o.diff   = '0;
      end
    endcase
  end

endmodule

/* sv/hpdc_queue.sv */
module hpdc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hpdc_pkg::hpdc_incr_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output hpdc_pkg::hpdc_incr_t item_o
);
  import hpdc_pkg::*;

  hpdc_incr_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer wrap at the queue depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

/* sv/hpdc_back.sv */
module hpdc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  hpdc_pkg::hpdc_incr_t        q_item_i,
  output logic                        q_pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [hpdc_pkg::OUT_W-1:0]  m_axis_tdata
);
  import hpdc_pkg::*;

  logic [CNT_W-1:0] same_q, same_d, either_q, either_d, diff_q, diff_d;
  logic [CNT_W-1:0] same_sum, either_sum, diff_sum;
  logic [OUT_W-1:0] out_q, out_d;
  logic             out_vld_q, out_vld_d;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] acc,
                                               logic [INC_W-1:0] inc);
    logic [CNT_W:0] s;
    s = {1'b0, acc} + (CNT_W + 1)'(inc);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // a last item needs the output register free or draining
  assign q_pop_o = q_valid_i && (!q_item_i.last || !out_vld_q || m_axis_tready);

  assign same_sum   = sat_add(same_q, q_item_i.same);
  assign either_sum = sat_add(either_q, q_item_i.either);
  assign diff_sum   = sat_add(diff_q, q_item_i.diff);

  always_comb begin
    same_d    = same_q;
    either_d  = either_q;
    diff_d    = diff_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    if (q_pop_o) begin
      if (q_item_i.last) begin
        out_d     = {diff_sum, either_sum, same_sum};
        out_vld_d = 1'b1;
        same_d    = '0;
        either_d  = '0;
        diff_d    = '0;
      end else begin
        same_d   = same_sum;
        either_d = either_sum;
        diff_d   = diff_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      same_q    <= '0;
      either_q  <= '0;
      diff_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      same_q    <= same_d;
      either_q  <= either_d;
      diff_q    <= diff_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

/* bench/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hpdc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX = 10;

  // same_in_both in the low bits, as on m_axis_tdata
  typedef struct packed {
    logic [CNT_W-1:0] differing;
    logic [CNT_W-1:0] present_in_either;
    logic [CNT_W-1:0] same_in_both;
  } pair_counts_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  // input stream, driven from the start of the run
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 s_axis_tlast = 1'b0;

  // output stream
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;

  haplotype_pair_distance_counts dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predicted counts of the pair in progress
  logic [CNT_W-1:0] same_cnt = '0;
  logic [CNT_W-1:0] either_cnt = '0;
  logic [CNT_W-1:0] diff_cnt = '0;

  // counts still owed by the block, oldest first
  pair_counts_t pending_counts [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          idle_en = 1'b1;
  int unsigned ready_hold = 0;

  // counts stop at the top instead of wrapping
  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] acc, int unsigned inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, acc} + (CNT_W+1)'(inc);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

  // fold one accepted item into the running counts, queue the counts on a last item
  task automatic tally_item(input hpdc_op_e op, input logic [DATA_W-1:0] wa,
                            input logic [DATA_W-1:0] wb, input logic [ALLELE_W-1:0] aa,
                            input logic [ALLELE_W-1:0] ab, input logic last_item);
    logic [DATA_W-1:0]   word_mask;
    logic [ALLELE_W-1:0] allele_mask;
    logic [DATA_W-1:0]   a_bits;
    logic [DATA_W-1:0]   b_bits;
    logic [ALLELE_W-1:0] a_allele;
    logic [ALLELE_W-1:0] b_allele;
    pair_counts_t        done;
    word_mask = (WORD_BITS >= DATA_W) ? '1 : ((DATA_W'(1) << WORD_BITS) - 1);
    allele_mask = (ALLELE_USE >= ALLELE_W) ? '1 : ((ALLELE_W'(1) << ALLELE_USE) - 1);
    if (op == OP_BIALLELIC) begin
      a_bits = wa & word_mask;
      b_bits = wb & word_mask;
      same_cnt = sat_add(same_cnt, $countones(a_bits & b_bits));
      either_cnt = sat_add(either_cnt, $countones(a_bits | b_bits));
      diff_cnt = sat_add(diff_cnt, $countones(a_bits ^ b_bits));
    end else begin
      a_allele = aa & allele_mask;
      b_allele = ab & allele_mask;
      // a site counts as shared only when neither side is the reference
      if (a_allele != '0 && b_allele != '0) begin
        either_cnt = sat_add(either_cnt, 1);
        if (a_allele == b_allele) begin
          same_cnt = sat_add(same_cnt, 1);
        end
      end
      if (a_allele != b_allele) begin
        diff_cnt = sat_add(diff_cnt, 1);
      end
    end
    if (last_item) begin
      done.same_in_both = same_cnt;
      done.present_in_either = either_cnt;
      done.differing = diff_cnt;
      pending_counts.push_back(done);
      same_cnt = '0;
      either_cnt = '0;
      diff_cnt = '0;
    end
  endtask

  // offer one item, wait for the handshake, then predict
  task automatic send_item(input hpdc_op_e op, input logic [DATA_W-1:0] wa,
                           input logic [DATA_W-1:0] wb, input logic [ALLELE_W-1:0] aa,
                           input logic [ALLELE_W-1:0] ab, input logic last_item);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ab, aa, wb, wa};
    s_axis_tuser <= op;
    s_axis_tlast <= last_item;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    tally_item(op, wa, wb, aa, ab, last_item);
  endtask

  // biallelic item with the allele fields filled with junk
  task automatic send_words(input logic [DATA_W-1:0] wa, input logic [DATA_W-1:0] wb,
                            input logic last_item);
    send_item(OP_BIALLELIC, wa, wb, ALLELE_W'($urandom), ALLELE_W'($urandom), last_item);
  endtask

  // multi-allelic item with the word fields filled with junk
  task automatic send_alleles(input logic [ALLELE_W-1:0] aa, input logic [ALLELE_W-1:0] ab,
                              input logic last_item);
    send_item(OP_MULTI, {$urandom, $urandom}, {$urandom, $urandom}, aa, ab, last_item);
  endtask

  // word with a mix of densities, including a final word padded with zeros
  function automatic logic [DATA_W-1:0] rand_word();
    logic [DATA_W-1:0] w;
    int unsigned       used;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = '1;
      2: w = w & {$urandom, $urandom} & {$urandom, $urandom};
      3: w = w | {$urandom, $urandom};
      4: begin
        used = $urandom_range(1, DATA_W - 1);
        w = w & ((DATA_W'(1) << used) - 1);
      end
      default: ;
    endcase
    return w;
  endfunction

  // alleles mostly small so that equal and reference values come up often
  function automatic logic [ALLELE_W-1:0] rand_allele();
    if ($urandom_range(0, 2) == 0) begin
      return ALLELE_W'($urandom);
    end
    return ALLELE_W'($urandom_range(0, 3));
  endfunction

  // word extremes, single-item pairs and a padded final word
  task automatic test_word_extremes();
    send_words('0, '0, 1'b1);
    send_words('1, '1, 1'b1);
    send_words('1, '0, 1'b0);
    send_words('0, '1, 1'b1);
    send_words(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_words(64'hFFFF_0000_FFFF_0000, 64'hFF00_FF00_FF00_FF00, 1'b0);
    send_words(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b0);
    // last word of the pair, only the low 13 variants present
    send_words(64'h0000_0000_0000_1ABC, 64'h0000_0000_0000_0F0F, 1'b1);
  endtask

  // reference, equal, unequal and extreme alleles, mixed with words
  task automatic test_allele_cases();
    send_alleles(8'd0, 8'd0, 1'b1);
    send_alleles(8'd0, 8'd5, 1'b0);
    send_alleles(8'd7, 8'd0, 1'b0);
    send_alleles(8'd3, 8'd3, 1'b0);
    send_alleles(8'd2, 8'd9, 1'b1);
    send_alleles(8'd255, 8'd255, 1'b0);
    send_alleles(8'd1, 8'd255, 1'b0);
    send_alleles(8'd255, 8'd0, 1'b0);
    send_words(64'hDEAD_BEEF_0123_4567, 64'h0F0F_1234_FFFF_0000, 1'b0);
    send_alleles(8'd128, 8'd128, 1'b1);
  endtask

  // well-formed pairs of random length with random content
  task automatic test_random_pairs(input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    int unsigned multi_pct;
    sent = 0;
    while (sent < n_items) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      multi_pct = $urandom_range(0, 100);
      for (int unsigned i = 0; i < run_len; i++) begin
        if ($urandom_range(1, 100) <= multi_pct) begin
          send_alleles(rand_allele(), rand_allele(), i == run_len - 1);
        end else begin
          send_words(rand_word(), rand_word(), i == run_len - 1);
        end
      end
      sent += run_len;
    end
  endtask

  // back to back items with input gaps and output stalls switched off
  task automatic test_steady_stream(input int unsigned n_items);
    idle_en = 1'b0;
    test_random_pairs(n_items);
  endtask

  // output side: random stall and ready bursts while idling is on
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_en && $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 13);
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold <= idle_en ? $urandom_range(0, 20) : 0;
    end
  end

  // compare each accepted result with the oldest expected counts
  always @(posedge clk_i) begin
    pair_counts_t want;
    pair_counts_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected result: same %0d either %0d diff %0d",
                   got.same_in_both, got.present_in_either, got.differing);
        end
      end else begin
        want = pending_counts.pop_front();
        if (got.same_in_both !== want.same_in_both
            || got.present_in_either !== want.present_in_either
            || got.differing !== want.differing) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch: same exp %0d got %0d, either exp %0d got %0d, diff exp %0d got %0d",
                     want.same_in_both, got.same_in_both,
                     want.present_in_either, got.present_in_either,
                     want.differing, got.differing);
          end
        end
      end
    end
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_word_extremes();
    test_allele_cases();
    test_random_pairs(1450);
    test_steady_stream(250);

    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* haplotype_pair_distance_counts.f */
+incdir+sv
sv/hpdc_pkg.sv
sv/hpdc_front.sv
sv/hpdc_queue.sv
sv/hpdc_back.sv
sv/haplotype_pair_distance_counts.sv
bench/testbench.sv
